// ===== src/sse_pkg.sv =====
// Shared types and constants for the selection sort engine.
package sse_pkg;

	localparam int WORD_W    = 32;
	localparam int SSE_DEPTH = 32;

	typedef logic signed [WORD_W-1:0] elem_t;

	typedef struct packed {
		elem_t value;
		logic  last;
	} in_word_t;

	typedef struct packed {
		elem_t sorted_value;
		logic  final_res;
	} out_word_t;

endpackage

// ===== src/sse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sse_ram #(
	parameter int Width = 32,
	parameter int Depth = 32,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [Width-1:0] wr_data,
	input  logic [AddrW-1:0] rd_addr,
	output logic [Width-1:0] rd_data
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== src/sse_cmp.sv =====
// Shared signed comparator used by the minimum search.
module sse_cmp (
	input  sse_pkg::elem_t a,
	input  sse_pkg::elem_t b,
	output logic           lt
);

	import sse_pkg::*;

	// Two's complement less-than on the full element width.
	assign lt = (a < b);

endmodule

// ===== src/selection_sort_engine_core.sv =====
// Top level of the selection sort engine: load, minimum search, swap and emit.
//
// Channel | Direction | Handshake           | Word
// --------+-----------+---------------------+------------------------------
// src     | into core | src_valid/src_stall | in_word_t  {value, last}
// snk     | out core  | snk_valid/snk_stall | out_word_t {sorted_value, final_res}
//
// Loading takes one cycle per word. A word marked last starts the sort, and the
// block holds src_stall high until the final sorted word has been handed to
// the output register. Each sorted position p is filled by a scan of the
// elements from p to the end of the set, one element read per cycle through
// the single RAM read port and the shared comparator, then by the swap writes
// of ST_SWAP_MIN and ST_SWAP_POS through the single write port.
// Reset clears the sequencer, the element count and the output valid; the
// element RAM is not cleared, since only entries written in the current set
// are read. A stalled output word holds the sequencer in its swap step.
module selection_sort_engine_core #(
	parameter int DEPTH = sse_pkg::SSE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  sse_pkg::in_word_t  src_word,
	output logic               snk_valid,
	input  logic               snk_stall,
	output sse_pkg::out_word_t snk_word
);

	import sse_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_SWAP_MIN,
		ST_SWAP_POS
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;    // elements held in the current set
	logic [CW-1:0]   rd_ptr_q;   // next RAM address to read during the scan
	logic [AW-1:0]   pos_q;      // position being filled
	logic [AW-1:0]   best_idx_q;
	elem_t           best_val_q;
	elem_t           pos_val_q;  // element found at pos_q, moved out on swap
	logic            d_vld_s1;   // RAM read data valid this cycle
	logic [AW-1:0]   d_idx_s1;   // address of that read data
	logic            out_vld_q;
	out_word_t       out_word_q;

	logic            src_acc;
	logic            snk_acc;
	logic            commit;
	logic            is_last_pos;
	logic            scan_done;
	logic            cmp_lt;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;
	elem_t           rd_val;

	assign src_stall = (state_q != ST_LOAD);
	assign src_acc   = src_valid && !src_stall;
	assign snk_acc   = out_vld_q && !snk_stall;
	assign snk_valid = out_vld_q;
	assign snk_word  = out_word_q;

	// The output register can take a new word when it is empty or draining.
	assign commit      = (state_q == ST_SWAP_POS) && (!out_vld_q || !snk_stall);
	assign is_last_pos = (CW'(pos_q) == count_q - CW'(1));
	assign scan_done   = d_vld_s1 && (CW'(d_idx_s1) == count_q - CW'(1));
	assign rd_val      = $signed(ram_rdata);

	sse_cmp u_cmp (
		.a  (rd_val),
		.b  (best_val_q),
		.lt (cmp_lt)
	);

	// Write port: loading, then the two halves of each swap.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = src_word.value;
		unique case (state_q)
			ST_LOAD: begin
				ram_we = src_acc && (count_q < CW'(DEPTH));
			end
			ST_SWAP_MIN: begin
				ram_we    = 1'b1;
				ram_waddr = best_idx_q;
				ram_wdata = pos_val_q;
			end
			ST_SWAP_POS: begin
				ram_we    = commit;
				ram_waddr = pos_q;
				ram_wdata = best_val_q;
			end
			ST_SCAN: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	sse_ram #(
		.Width (WORD_W),
		.Depth (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (rd_ptr_q[AW-1:0]),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			rd_ptr_q   <= '0;
			pos_q      <= '0;
			d_vld_s1   <= 1'b0;
			out_vld_q  <= 1'b0;
			best_idx_q <= '0;
			d_idx_s1   <= '0;
		end else begin
			// A new word fills the output register; otherwise a taken word empties it.
			if (commit) begin
				out_vld_q <= 1'b1;
			end else if (snk_acc) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (src_acc) begin
						// A word beyond the store depth is dropped, but last still sorts.
						if (count_q < CW'(DEPTH)) begin
							count_q <= count_q + CW'(1);
						end
						if (src_word.last) begin
							state_q  <= ST_SCAN;
							pos_q    <= '0;
							rd_ptr_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					// Once the last address has been issued the read pointer equals the
					// count, so the valid flag drops as the final element is compared.
					if (rd_ptr_q < count_q) begin
						rd_ptr_q <= rd_ptr_q + CW'(1);
						d_vld_s1 <= 1'b1;
						d_idx_s1 <= rd_ptr_q[AW-1:0];
					end else begin
						d_vld_s1 <= 1'b0;
					end
					if (d_vld_s1) begin
						// The first element read seeds the running minimum; later ones
						// replace it only when strictly smaller, keeping the first index.
						if (d_idx_s1 == pos_q) begin
							best_val_q <= rd_val;
							pos_val_q  <= rd_val;
							best_idx_q <= d_idx_s1;
						end else if (cmp_lt) begin
							best_val_q <= rd_val;
							best_idx_q <= d_idx_s1;
						end
					end
					if (scan_done) begin
						state_q <= ST_SWAP_MIN;
					end
				end
				ST_SWAP_MIN: begin
					state_q <= ST_SWAP_POS;
				end
				ST_SWAP_POS: begin
					if (commit) begin
						out_word_q.sorted_value <= best_val_q;
						out_word_q.final_res    <= is_last_pos;
						if (is_last_pos) begin
							state_q <= ST_LOAD;
							count_q <= '0;
						end else begin
							pos_q    <= pos_q + AW'(1);
							rd_ptr_q <= CW'(pos_q) + CW'(1);
							state_q  <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// ===== src/sse_chk.sv =====
// Port-level assertions for the selection sort engine, bound to the top level.
module sse_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               src_valid,
	input logic               src_stall,
	input sse_pkg::in_word_t  src_word,
	input logic               snk_valid,
	input logic               snk_stall,
	input sse_pkg::out_word_t snk_word
);

	import sse_pkg::*;

	// A stalled result word stays offered.
	a_snk_hold: assert property (@(posedge clk) disable iff (!arst_n)
		snk_valid && snk_stall |=> snk_valid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its contents.
	a_snk_stable: assert property (@(posedge clk) disable iff (!arst_n)
		snk_valid && snk_stall |=> $stable(snk_word))
		else $error("result word changed while stalled");

	// A word marked last starts the sort, so the input side closes next cycle.
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall && src_word.last |=> src_stall)
		else $error("input accepted right after the last word of a set");

	// Until the final sorted word is out, the input side stays closed.
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		snk_valid && !snk_stall && !snk_word.final_res |-> src_stall)
		else $error("input open while a sorted run is still in progress");

endmodule

bind selection_sort_engine_core sse_chk u_sse_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_valid (src_valid),
	.src_stall (src_stall),
	.src_word  (src_word),
	.snk_valid (snk_valid),
	.snk_stall (snk_stall),
	.snk_word  (snk_word)
);

// ===== verif/tb_selection_sort_engine_core.sv =====
// Self-checking testbench for selection_sort_engine_core against a local sorter.
module tb_selection_sort_engine_core;
	timeunit 1ns;
	timeprecision 1ps;

	import sse_pkg::*;

	// CYCLE_LIMIT sits well above the slowest legal run: about 200 words with the widest
	// sender gap, a handful of full-depth sorts, and one sorted word per input word
	// under the longest receiver stall.
	localparam int CYCLE_LIMIT   = 200000;
	localparam int MAX_GAP       = 11;
	localparam int RANDOM_WORDS  = 75;
	localparam int SETTLE_CYCLES = 40;
	localparam int SHOWN_ERRORS  = 10;

	localparam elem_t ELEM_MAX = 32'sh7FFF_FFFF;
	localparam elem_t ELEM_MIN = 32'sh8000_0000;

	// Value flavors for random sets: the full range, a narrow band that forces ties,
	// and a mix weighted toward the two's complement extremes.
	typedef enum int {PICK_FULL, PICK_NARROW, PICK_EDGE} pick_t;

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_stall;
	in_word_t  src_word;
	logic      snk_valid;
	logic      snk_stall;
	out_word_t snk_word;

	// When clear, neither side inserts idle cycles, so words move back to back.
	bit throttle;

	// Local copy of the set being loaded and the sorted words still owed by the block.
	elem_t     loaded_elems [SSE_DEPTH];
	int        loaded_count;
	out_word_t sorted_words_due [$];

	int mismatches;
	int words_sent;
	int cycle_count;

	selection_sort_engine_core #(
		.DEPTH(SSE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_word (src_word),
		.snk_valid(snk_valid),
		.snk_stall(snk_stall),
		.snk_word (snk_word)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a lost sorted word ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Counts a mismatch and tells the caller whether it is still worth printing.
	function automatic bit log_mismatch();
		mismatches++;
		return mismatches <= SHOWN_ERRORS;
	endfunction

	function automatic elem_t rand_elem(pick_t pick);
		case (pick)
			PICK_NARROW: begin
				return $signed($urandom_range(0, 8)) - 32'sd4;
			end
			PICK_EDGE: begin
				case ($urandom_range(0, 5))
					0: return ELEM_MAX;
					1: return ELEM_MIN;
					2: return 32'sd0;
					3: return -32'sd1;
					4: return ELEM_MIN + $signed($urandom_range(0, 3));
					default: return $urandom;
				endcase
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// Mirrors the block on one accepted word. Words past the store depth are dropped,
	// but a dropped word marked last still sorts and emits what was stored. The sort
	// is plain selection sort: the first index of the remaining minimum moves into
	// place, so equal values keep no distinguishable order.
	function automatic void absorb_word(elem_t value, logic last);
		int        p;
		int        k;
		int        best;
		elem_t     held;
		out_word_t owed;
		if (loaded_count < SSE_DEPTH) begin
			loaded_elems[loaded_count] = value;
			loaded_count++;
		end
		if (last) begin
			for (p = 0; p < loaded_count; p++) begin
				best = p;
				for (k = p + 1; k < loaded_count; k++) begin
					if (loaded_elems[k] < loaded_elems[best])
						best = k;
				end
				held               = loaded_elems[p];
				loaded_elems[p]    = loaded_elems[best];
				loaded_elems[best] = held;
			end
			for (k = 0; k < loaded_count; k++) begin
				owed.sorted_value = loaded_elems[k];
				owed.final_res    = (k == loaded_count - 1);
				sorted_words_due.push_back(owed);
			end
			loaded_count = 0;
		end
	endfunction

	// Offers one word, after a random gap when throttled, and holds it until the block takes it.
	// Valid is only lowered when a gap is drawn, so consecutive words never see a
	// lower and raise of valid within the same time step.
	task automatic send_word(elem_t value, logic last);
		int gap;
		gap = throttle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_word  <= '{value: value, last: last};
		do @(posedge clk); while (src_stall);
		absorb_word(value, last);
		words_sent++;
	endtask

	task automatic send_list(elem_t vals [$]);
		int k;
		for (k = 0; k < vals.size(); k++)
			send_word(vals[k], k == vals.size() - 1);
	endtask

	task automatic send_set(int n, pick_t pick);
		int k;
		for (k = 0; k < n; k++)
			send_word(rand_elem(pick), k == n - 1);
	endtask

	// Holds the sender off until every sorted word owed so far has been taken.
	task automatic wait_for_drain();
		src_valid <= 1'b0;
		@(posedge clk);
		while (sorted_words_due.size() != 0)
			@(posedge clk);
	endtask

	// Two one-word sets in a row: the word itself is the final sorted word.
	task automatic test_single_word_sets();
		send_word(ELEM_MIN, 1'b1);
		send_word(ELEM_MAX, 1'b1);
	endtask

	// Both ends of the signed range, zero and the values next to them.
	task automatic test_extreme_values();
		elem_t vals [$];
		vals = {32'sd0, ELEM_MAX, ELEM_MIN, -32'sd1, 32'sd1, ELEM_MAX - 32'sd1,
			ELEM_MIN + 32'sd1};
		send_list(vals);
	endtask

	// Repeated values exercise the first-index rule of the minimum search.
	task automatic test_equal_values();
		elem_t vals [$];
		vals = {32'sd3, -32'sd3, 32'sd3, 32'sd3, -32'sd3, 32'sd0, 32'sd3};
		send_list(vals);
	endtask

	// A strictly descending set sent with no sender idling, then a full drain.
	task automatic test_back_to_back_descending();
		elem_t vals [$];
		vals = {32'sd5, 32'sd4, 32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1};
		throttle = 1'b0;
		send_list(vals);
		throttle = 1'b1;
		wait_for_drain();
	endtask

	// Exactly DEPTH words: the word marked last is the one that fills the store.
	task automatic test_full_store();
		send_set(SSE_DEPTH, PICK_FULL);
	endtask

	// More words than the store holds: the extra ones are dropped, including the
	// one marked last, which still starts the sort of the stored DEPTH words.
	task automatic test_store_overflow();
		send_set(SSE_DEPTH + 1, PICK_NARROW);
		send_set(SSE_DEPTH + $urandom_range(2, 8), PICK_EDGE);
	endtask

	// Mostly short sets, some up to full depth and a few past it, with random value
	// flavors, idling switched off for whole sets now and then, and an occasional
	// pause until the block has emitted everything.
	task automatic test_random_sets();
		int    first_word;
		int    n;
		int    roll;
		pick_t pick;
		first_word = words_sent;
		while (words_sent - first_word < RANDOM_WORDS) begin
			throttle = ($urandom_range(0, 3) != 0);
			roll     = $urandom_range(0, 19);
			if (roll < 15)
				n = $urandom_range(1, 8);
			else if (roll < 19)
				n = $urandom_range(9, SSE_DEPTH);
			else
				n = $urandom_range(SSE_DEPTH + 1, SSE_DEPTH + 6);
			pick = pick_t'($urandom_range(0, 2));
			send_set(n, pick);
			if ($urandom_range(0, 7) == 0)
				wait_for_drain();
		end
		throttle = 1'b1;
	endtask

	// Receiver: before each sorted word it stalls for a random count of cycles,
	// then keeps stall low until a word is taken.
	initial begin : sink_side
		int hold;
		snk_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = throttle ? $urandom_range(0, MAX_GAP) : 0;
			if (hold > 0) begin
				snk_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			snk_stall <= 1'b0;
			do @(posedge clk); while (!(snk_valid && !snk_stall));
		end
	end

	// Every word taken from the block is compared field by field with the oldest
	// sorted word still owed. Failures are counted and the run carries on.
	always @(posedge clk) begin : check_sorted
		out_word_t owed;
		if (arst_n && snk_valid && !snk_stall) begin
			if (sorted_words_due.size() == 0) begin
				if (log_mismatch())
					$display("unexpected sorted word: value %0d final %0b",
						snk_word.sorted_value, snk_word.final_res);
			end else begin
				owed = sorted_words_due.pop_front();
				if (snk_word.sorted_value !== owed.sorted_value ||
					snk_word.final_res !== owed.final_res) begin
					if (log_mismatch())
						$display({"sorted word mismatch: expected value %0d final %0b,",
							" got value %0d final %0b"},
							owed.sorted_value, owed.final_res,
							snk_word.sorted_value, snk_word.final_res);
				end
			end
		end
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		src_valid    = 1'b0;
		src_word     = '0;
		throttle     = 1'b1;
		loaded_count = 0;
		mismatches   = 0;
		words_sent   = 0;
		cycle_count  = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_word_sets();
		test_extreme_values();
		test_equal_values();
		test_back_to_back_descending();
		test_full_store();
		test_store_overflow();
		test_random_sets();

		// All stimulus is in: wait out the remaining sorted words, then keep watching
		// in case the block emits anything it should not.
		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && sorted_words_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
